// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge out of reset.
`define FK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication between two expressions.
`define FK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/fk_pkg.sv
// ----------------------------------------------------------------------------
// fk_pkg
// Shared widths, register indexes, CORDIC constants and word types.
// ----------------------------------------------------------------------------
`default_nettype none

package fk_pkg;

  localparam int AngW     = 16;  // joint angle, 65536 units per turn
  localparam int PosW     = 16;  // signed Q7.8 position
  localparam int LenW     = 15;  // unsigned Q7.8 link length
  localparam int CfgW     = 16;  // widest register
  localparam int CfgAddrW = 3;
  localparam int InTdataW = 80;  // five 16-bit fields
  localparam int TrigW    = 18;  // Q2.14 sine / cosine with headroom
  localparam int CordW    = 34;  // CORDIC x, y and residual angle

  localparam logic signed [CordW-1:0] CordicGain = CordW'(652032874);

  typedef enum logic [CfgAddrW-1:0] {
    RegLink1Len = 3'd0,
    RegLink2Len = 3'd1,
    RegBaseX    = 3'd2,
    RegBaseY    = 3'd3,
    RegBaseZ    = 3'd4
  } fk_reg_e;

  typedef struct packed {
    logic signed [TrigW-1:0] sin1;
    logic signed [TrigW-1:0] cos1;
    logic signed [TrigW-1:0] sin2;
    logic signed [TrigW-1:0] cos2;
  } fk_trig_t;

  // Point carried alongside the CORDIC; py already holds the link2 offset.
  typedef struct packed {
    logic signed [PosW-1:0] pz;
    logic signed [PosW:0]   py;
    logic signed [PosW-1:0] px;
  } fk_point_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic signed [CordW-1:0] atan_step(input int idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10679838;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      default: v = 32'd0;
    endcase
    return $signed({{(CordW-32){1'b0}}, v});
  endfunction

endpackage

`default_nettype wire

// File: design/two_link_forward_kinematics_top.sv
// ----------------------------------------------------------------------------
// two_link_forward_kinematics_top
// Maps a point in the second link's frame to world coordinates through two
// z rotations by CORDIC sine and cosine, with saturating Q7.8 results.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                    word
//  --------  ---  ---------------------------  ----------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready  angle1, angle2, px, py, pz
//  m_axis    out  m_axis_tvalid/m_axis_tready  world_x, world_y, world_z, sat
//  cfg       in   cfg_we_i (no wait)           cfg_addr_i selects, cfg_wdata_i
//
//  One word enters per cycle unless every stage is full and stalled. There is one load
//  stage, one stage per CORDIC step and a rounding stage in fk_cordic, then
//  two multiply stages, two rounding stages and the saturating output
//  register. Each stage holds only while its successor is full and stalled,
//  so bubbles close up behind a stalled output and input keeps flowing until
//  every stage is occupied. Reset empties the pipeline and loads the link
//  lengths and base offset with their defaults; nothing needs clearing.
//
`default_nettype none

`include "assert_macros.svh"

module two_link_forward_kinematics_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [fk_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [fk_pkg::CfgW-1:0]        cfg_wdata_i,
  // input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // from bit 0: first_joint_angle, second_joint_angle, point_x, point_y, point_z
  input  logic [fk_pkg::InTdataW-1:0]    s_axis_tdata,
  // result words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // from bit 0: world_x, world_y, world_z, saturated, zero fill
  output logic [((3*COORD_WIDTH+8)/8)*8-1:0] m_axis_tdata
);
  import fk_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int PW   = 36;                         // first rotation products
  localparam int X1W  = 20;                         // link2 frame coordinate
  localparam int QW   = 40;                         // second rotation products
  localparam int X0W  = 22;                         // rotated world coordinate
  localparam int FW   = ((CW > X0W) ? CW : X0W) + 2;  // sum before clipping
  localparam longint HiL = (longint'(1) <<< (CW - 1)) - 1;
  localparam logic signed [FW-1:0] Hi = FW'(HiL);
  localparam logic signed [FW-1:0] Lo = FW'(-HiL - 1);
  localparam int NT   = 5;                          // stages after the CORDIC

  // ---------------------------------------------------------------- registers
  logic [LenW-1:0]        link1_q, link2_q;
  logic signed [PosW-1:0] base_x_q, base_y_q, base_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link1_q  <= LenW'(128);
      link2_q  <= LenW'(128);
      base_x_q <= PosW'(0);
      base_y_q <= PosW'(768);
      base_z_q <= PosW'(256);
    end else if (cfg_we_i) begin
      unique case (fk_reg_e'(cfg_addr_i))
        RegLink1Len: link1_q  <= cfg_wdata_i[LenW-1:0];
        RegLink2Len: link2_q  <= cfg_wdata_i[LenW-1:0];
        RegBaseX:    base_x_q <= cfg_wdata_i;
        RegBaseY:    base_y_q <= cfg_wdata_i;
        RegBaseZ:    base_z_q <= cfg_wdata_i;
        default:     ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  fk_point_t pt_in;
  logic [PosW-1:0] in_py;

  assign in_py       = s_axis_tdata[4*PosW-1:3*PosW];
  assign pt_in.px    = s_axis_tdata[3*PosW-1:2*PosW];
  assign pt_in.pz    = s_axis_tdata[5*PosW-1:4*PosW];
  // shift the point out along link 2 before it enters the pipeline
  assign pt_in.py    = $signed({in_py[PosW-1], in_py} + {2'b00, link2_q});

  // ---------------------------------------------------------------- sin/cos
  logic      cv_valid, cv_ready;
  fk_trig_t  cv_trig;
  fk_point_t cv_pt;

  fk_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .angle1_i    (s_axis_tdata[AngW-1:0]),
    .angle2_i    (s_axis_tdata[2*AngW-1:AngW]),
    .point_i     (pt_in),
    .out_valid_o (cv_valid),
    .out_ready_i (cv_ready),
    .trig_o      (cv_trig),
    .point_o     (cv_pt)
  );

  // ---------------------------------------------------------------- stall chain
  logic [NT-1:0] t_vld_q;
  logic [NT:0]   t_en;

  assign t_en[NT] = m_axis_tready;
  for (genvar k = 0; k < NT; k++) begin : g_ten
    assign t_en[k] = !t_vld_q[k] || t_en[k+1];
  end
  assign cv_ready      = t_en[0];
  assign m_axis_tvalid = t_vld_q[NT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q <= '0;
    end else begin
      if (t_en[0]) t_vld_q[0] <= cv_valid;
      for (int k = 1; k < NT; k++) begin
        if (t_en[k]) t_vld_q[k] <= t_vld_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  // stage 1: rotate by the second joint (products)
  logic signed [PW-1:0]    pa_q, pb_q, pc_q, pd_q;
  logic signed [TrigW-1:0] s1a_q, c1a_q, s1b_q, c1b_q;
  logic signed [PosW-1:0]  pza_q, pzb_q, pzc_q, pzd_q;
  // stage 2: round to the link2 frame
  logic signed [X1W-1:0]   x1_q, y1r_q;
  logic signed [PW-1:0]    sum_a, sum_b;
  // stage 3: add link1, rotate by the first joint (products)
  logic signed [X1W-1:0]   y1;
  logic signed [QW-1:0]    qa_q, qb_q, qc_q, qd_q;
  // stage 4: round to world axes
  logic signed [QW-1:0]    sum_c, sum_d;
  logic signed [X0W-1:0]   x0_q, y0_q;
  // stage 5: offset and clip
  logic signed [FW-1:0]    fin [0:2];
  logic [CW-1:0]           w_d [0:2];
  logic [CW-1:0]           wx_q, wy_q, wz_q;
  logic                    sat_d, sat_q;

  assign sum_a = pa_q - pb_q;
  assign sum_b = pc_q + pd_q;
  assign y1    = y1r_q + X1W'(link1_q);
  assign sum_c = qa_q - qb_q;
  assign sum_d = qc_q + qd_q;

  always_comb begin
    fin[0] = FW'(x0_q) + FW'(base_x_q);
    fin[1] = FW'(y0_q) + FW'(base_y_q);
    fin[2] = FW'(pzd_q) + FW'(base_z_q);
    sat_d  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (fin[i] > Hi) begin
        w_d[i] = Hi[CW-1:0];
        sat_d  = 1'b1;
      end else if (fin[i] < Lo) begin
        w_d[i] = Lo[CW-1:0];
        sat_d  = 1'b1;
      end else begin
        w_d[i] = fin[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (t_en[0]) begin
      pa_q  <= PW'(cv_trig.cos2) * PW'(cv_pt.px);
      pb_q  <= PW'(cv_trig.sin2) * PW'(cv_pt.py);
      pc_q  <= PW'(cv_trig.sin2) * PW'(cv_pt.px);
      pd_q  <= PW'(cv_trig.cos2) * PW'(cv_pt.py);
      s1a_q <= cv_trig.sin1;
      c1a_q <= cv_trig.cos1;
      pza_q <= cv_pt.pz;
    end
    if (t_en[1]) begin
      x1_q  <= X1W'((sum_a + PW'(8192)) >>> 14);
      y1r_q <= X1W'((sum_b + PW'(8192)) >>> 14);
      s1b_q <= s1a_q;
      c1b_q <= c1a_q;
      pzb_q <= pza_q;
    end
    if (t_en[2]) begin
      qa_q  <= QW'(c1b_q) * QW'(x1_q);
      qb_q  <= QW'(s1b_q) * QW'(y1);
      qc_q  <= QW'(s1b_q) * QW'(x1_q);
      qd_q  <= QW'(c1b_q) * QW'(y1);
      pzc_q <= pzb_q;
    end
    if (t_en[3]) begin
      x0_q  <= X0W'((sum_c + QW'(8192)) >>> 14);
      y0_q  <= X0W'((sum_d + QW'(8192)) >>> 14);
      pzd_q <= pzc_q;
    end
    if (t_en[4]) begin
      wx_q  <= w_d[0];
      wy_q  <= w_d[1];
      wz_q  <= w_d[2];
      sat_q <= sat_d;
    end
  end

  always_comb begin
    m_axis_tdata              = '0;
    m_axis_tdata[CW-1:0]      = wx_q;
    m_axis_tdata[2*CW-1:CW]   = wy_q;
    m_axis_tdata[3*CW-1:2*CW] = wz_q;
    m_axis_tdata[3*CW]        = sat_q;
  end

  `FK_ASSERT_IMPL(a_full_when_blocked, !t_en[0], &t_vld_q, "rotation stages block with a free stage")
  `FK_ASSERT_IMPL(a_sat_at_rail, m_axis_tvalid && sat_q, (wx_q == Hi[CW-1:0]) || (wx_q == Lo[CW-1:0]) || (wy_q == Hi[CW-1:0]) || (wy_q == Lo[CW-1:0]) || (wz_q == Hi[CW-1:0]) || (wz_q == Lo[CW-1:0]), "saturated flag without a clipped coordinate")
  `FK_ASSERT(a_out_from_prev, $rose(m_axis_tvalid) |-> $past(t_vld_q[NT-2]), "result word without a word behind it")

endmodule

`default_nettype wire

// File: design/fk_cordic.sv
// ----------------------------------------------------------------------------
// fk_cordic
// Two-lane unrolled rotation CORDIC: sine and cosine of both joint angles,
// one step per stage, with the point word carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fk_cordic #(
  parameter int STEPS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fk_pkg::AngW-1:0]     angle1_i,
  input  logic [fk_pkg::AngW-1:0]     angle2_i,
  input  fk_pkg::fk_point_t           point_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output fk_pkg::fk_trig_t            trig_o,
  output fk_pkg::fk_point_t           point_o
);
  import fk_pkg::*;

  // stage 0 loads, stages 1..STEPS iterate, stage STEPS+1 rounds
  localparam int NStg = STEPS + 2;
  localparam logic signed [CordW-1:0] RndHalf = CordW'(32768);
  localparam logic signed [CordW-1:0] ZBound  =
      (atan_step(STEPS - 1) <<< 1) + CordW'(STEPS);

  logic [NStg-1:0] vld_q;
  logic [NStg:0]   en;

  logic signed [CordW-1:0] x_q [0:STEPS][0:1];
  logic signed [CordW-1:0] y_q [0:STEPS][0:1];
  logic signed [CordW-1:0] z_q [0:STEPS][0:1];
  logic signed [CordW-1:0] x_d [0:STEPS][0:1];
  logic signed [CordW-1:0] y_d [0:STEPS][0:1];
  logic signed [CordW-1:0] z_d [0:STEPS][0:1];
  logic [1:0]              neg_q [0:STEPS];
  logic [1:0]              neg_d;
  fk_point_t               pt_q [0:NStg-1];
  fk_trig_t                trig_q, trig_d;

  logic [AngW-1:0]         ang [0:1];
  logic [AngW-1:0]         ang_red [0:1];
  logic signed [CordW-1:0] rx [0:1];
  logic signed [CordW-1:0] ry [0:1];

  // a stage loads when it is empty or its word moves on
  assign en[NStg] = out_ready_i;
  for (genvar k = 0; k < NStg; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NStg-1];
  assign trig_o      = trig_q;
  assign point_o     = pt_q[NStg-1];

  assign ang[0] = angle1_i;
  assign ang[1] = angle2_i;

  always_comb begin
    // fold the second and third quadrants by half a turn
    for (int l = 0; l < 2; l++) begin
      neg_d[l]   = ang[l][AngW-1] ^ ang[l][AngW-2];
      ang_red[l] = neg_d[l] ? (ang[l] ^ {1'b1, {(AngW-1){1'b0}}}) : ang[l];
      x_d[0][l]  = CordicGain;
      y_d[0][l]  = '0;
      z_d[0][l]  = CordW'($signed({ang_red[l], 16'h0000}));
    end
    // one micro-rotation per stage
    for (int k = 1; k <= STEPS; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (!z_q[k-1][l][CordW-1]) begin
          x_d[k][l] = x_q[k-1][l] - (y_q[k-1][l] >>> (k - 1));
          y_d[k][l] = y_q[k-1][l] + (x_q[k-1][l] >>> (k - 1));
          z_d[k][l] = z_q[k-1][l] - atan_step(k - 1);
        end else begin
          x_d[k][l] = x_q[k-1][l] + (y_q[k-1][l] >>> (k - 1));
          y_d[k][l] = y_q[k-1][l] - (x_q[k-1][l] >>> (k - 1));
          z_d[k][l] = z_q[k-1][l] + atan_step(k - 1);
        end
      end
    end
    // undo the fold and round to Q2.14
    for (int l = 0; l < 2; l++) begin
      rx[l] = neg_q[STEPS][l] ? (RndHalf - x_q[STEPS][l]) : (x_q[STEPS][l] + RndHalf);
      ry[l] = neg_q[STEPS][l] ? (RndHalf - y_q[STEPS][l]) : (y_q[STEPS][l] + RndHalf);
    end
    trig_d.cos1 = TrigW'(rx[0] >>> 16);
    trig_d.sin1 = TrigW'(ry[0] >>> 16);
    trig_d.cos2 = TrigW'(rx[1] >>> 16);
    trig_d.sin2 = TrigW'(ry[1] >>> 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      neg_q[0] <= neg_d;
      pt_q[0]  <= point_i;
    end
    for (int k = 0; k <= STEPS; k++) begin
      if (en[k]) begin
        for (int l = 0; l < 2; l++) begin
          x_q[k][l] <= x_d[k][l];
          y_q[k][l] <= y_d[k][l];
          z_q[k][l] <= z_d[k][l];
        end
      end
    end
    for (int k = 1; k <= STEPS; k++) begin
      if (en[k]) neg_q[k] <= neg_q[k-1];
    end
    for (int k = 1; k < NStg; k++) begin
      if (en[k]) pt_q[k] <= pt_q[k-1];
    end
    if (en[NStg-1]) trig_q <= trig_d;
  end

  `FK_ASSERT_IMPL(a_full_when_blocked, !in_ready_o, &vld_q, "cordic blocks input with a free stage")
  `FK_ASSERT_IMPL(a_residual_small, vld_q[STEPS], (z_q[STEPS][0] <= ZBound) && (z_q[STEPS][0] >= -ZBound) && (z_q[STEPS][1] <= ZBound) && (z_q[STEPS][1] >= -ZBound), "cordic residual angle did not converge")
  `FK_ASSERT(a_out_from_prev, $rose(out_valid_o) |-> $past(vld_q[NStg-2]), "cordic output valid without a word behind it")

endmodule

`default_nettype wire

// File: dv/two_link_forward_kinematics_top_tb.sv
// ----------------------------------------------------------------------------
// two_link_forward_kinematics_top_tb
// Drives joint-angle and point words into the two-link forward kinematics
// block and checks every result word against a CORDIC-exact predictor held
// here. Runs a short directed table at the reset settings, then random
// phases at several link and base-offset settings with varying back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module two_link_forward_kinematics_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fk_pkg::*;

  localparam int CordicSteps = 16;
  localparam longint CordicGainQ30 = 64'sd652032874;
  // register indexes that decode to nothing
  localparam logic [CfgAddrW-1:0] AddrSpareLo = 3'd5;
  localparam logic [CfgAddrW-1:0] AddrSpareHi = 3'd7;
  localparam int ItemsPerPhase = 125;
  localparam int NumPhases = 6;
  localparam int RxHoldCycles = 80;  // well past the pipeline depth

  // Input word, first field in the lowest bits.
  typedef struct packed {
    logic signed [15:0] pz;
    logic signed [15:0] py;
    logic signed [15:0] px;
    logic [15:0]        ang2;
    logic [15:0]        ang1;
  } kin_word_t;

  // Result word, first field in the lowest bits.
  typedef struct packed {
    logic [6:0]         fill;
    logic               sat;
    logic signed [15:0] wz;
    logic signed [15:0] wy;
    logic signed [15:0] wx;
  } world_word_t;

  // Directed row: stimulus, plus world_z and the clip flag where they are
  // obvious from the settings; x and y always come from the predictor.
  typedef struct packed {
    logic [15:0] a1;
    logic [15:0] a2;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic        known;
    logic        sat_exp;
    logic [15:0] z_exp;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgAddrW-1:0]    cfg_addr_i;
  logic [CfgW-1:0]        cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // from bit 0: first_joint_angle, second_joint_angle, point_x, point_y, point_z
  logic [InTdataW-1:0]    s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // from bit 0: world_x, world_y, world_z, saturated, zero fill
  logic [55:0]            m_axis_tdata;

  // predictor's copy of the registers
  logic [14:0]        link1_len;
  logic [14:0]        link2_len;
  logic signed [15:0] base_x;
  logic signed [15:0] base_y;
  logic signed [15:0] base_z;

  world_word_t pending_world [$];
  int          results_seen;
  int          mismatches;
  int          tx_idle_pct;
  int          rx_idle_pct;

  // atan(2^-i), 2^32 units per turn
  longint atan_units [0:15] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  // Quadrant edges, extremes of every field, the clip boundary on z.
  dir_row_t dir_rows [0:22] = '{
    {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0100},
    {16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0100},
    {16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0100},
    {16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0100},
    {16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0100},
    {16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0100},
    {16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0100},
    {16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0100},
    {16'h3FFF, 16'hBFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0100},
    {16'h4001, 16'hC001, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0100},
    {16'h7FFF, 16'h8001, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0100},
    {16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
    {16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
    {16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 1'b1, 1'b1, 16'h0100},
    {16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b1, 1'b0, 16'h0100},
    {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 1'b1, 1'b1, 16'h7FFF},
    {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b1, 1'b0, 16'h8100},
    {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7F00, 1'b1, 1'b1, 16'h7FFF},
    {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7EFF, 1'b1, 1'b0, 16'h7FFF},
    {16'h2000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0000},
    {16'h6000, 16'hA000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0000},
    {16'h1234, 16'hABCD, 16'h5555, 16'hAAAA, 16'h1234, 1'b0, 1'b0, 16'h0000},
    {16'hEDCB, 16'h5432, 16'hAAAA, 16'h5555, 16'hEDCB, 1'b0, 1'b0, 16'h0000}
  };

  two_link_forward_kinematics_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Rotation-mode CORDIC; fold the outer half-turn quadrants onto the inner
  // ones and negate the outputs, then round both to Q2.14.
  function automatic void sin_cos_q14(input logic [15:0] ang,
                                      output longint s, output longint c);
    logic [15:0] a;
    logic        flip;
    longint      x, y, z, dx, dy;
    int          i;
    a = ang;
    flip = (a[15:14] == 2'b01) || (a[15:14] == 2'b10);
    if (flip) a[15] = ~a[15];
    z = longint'($signed(a)) * 65536;
    x = CordicGainQ30;
    y = 0;
    for (i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_units[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_units[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x + 32768) >>> 16;
    s = (y + 32768) >>> 16;
  endfunction

  // Q.22 product sum down to Q.8, round half up
  function automatic longint round_to_q8(input longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic logic [15:0] clamp_q78(input longint v, inout logic clipped);
    if (v > 32767) begin
      clipped = 1'b1;
      return 16'h7FFF;
    end
    if (v < -32768) begin
      clipped = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic world_word_t predict_world(input kin_word_t w);
    longint      s1, c1, s2, c2, px, py, pz, x1, y1, x0, y0;
    logic        clipped;
    world_word_t r;
    sin_cos_q14(w.ang1, s1, c1);
    sin_cos_q14(w.ang2, s2, c2);
    px = longint'($signed(w.px));
    py = longint'($signed(w.py)) + longint'(link2_len);
    pz = longint'($signed(w.pz));
    // second joint, then shift along the first link, then first joint
    x1 = round_to_q8(c2 * px - s2 * py);
    y1 = round_to_q8(s2 * px + c2 * py) + longint'(link1_len);
    x0 = round_to_q8(c1 * x1 - s1 * y1);
    y0 = round_to_q8(s1 * x1 + c1 * y1);
    clipped = 1'b0;
    r.fill = '0;
    r.wx = clamp_q78(x0 + longint'(base_x), clipped);
    r.wy = clamp_q78(y0 + longint'(base_y), clipped);
    r.wz = clamp_q78(pz + longint'(base_z), clipped);
    r.sat = clipped;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers; all are entered and left at a falling edge
  // --------------------------------------------------------------------------

  // Write one register and mirror it in the predictor; leaves the enable
  // high so back-to-back writes need no gap.
  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegLink1Len: link1_len = val[14:0];
      RegLink2Len: link2_len = val[14:0];
      RegBaseX:    base_x = val;
      RegBaseY:    base_y = val;
      RegBaseZ:    base_z = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Offer one word, with random idle cycles ahead of it, and log its
  // expected result once the block takes it.
  task automatic send_word(input kin_word_t w, input world_word_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_world.push_back(want);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_world.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_angle();
    if ($urandom_range(3) != 0) return 16'($urandom);
    case ($urandom_range(8))
      0: return 16'h0000;
      1: return 16'h3FFF;
      2: return 16'h4000;
      3: return 16'h4001;
      4: return 16'h7FFF;
      5: return 16'h8000;
      6: return 16'hBFFF;
      7: return 16'hC000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Half within +/-8.0 so results stay in range, the rest full scale.
  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(7);
    if (r == 0) return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
    if (r < 5) return 16'($urandom_range(4095)) - 16'd2048;
    return 16'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    kin_word_t   w;
    world_word_t want;
    int          p, k, n;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    tx_idle_pct   = 33;
    rx_idle_pct   = 63;
    // reset values of the registers
    link1_len = 15'd128;
    link2_len = 15'd128;
    base_x    = 16'sd0;
    base_y    = 16'sd768;
    base_z    = 16'sd256;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table at the reset settings.
    for (n = 0; n < 23; n++) begin
      w.ang1 = dir_rows[n].a1;
      w.ang2 = dir_rows[n].a2;
      w.px   = dir_rows[n].px;
      w.py   = dir_rows[n].py;
      w.pz   = dir_rows[n].pz;
      want = predict_world(w);
      if (dir_rows[n].known) begin
        want.wz  = dir_rows[n].z_exp;
        want.sat = dir_rows[n].sat_exp;
      end
      send_word(w, want);
    end

    // Random phases. Each one starts idle: drain, reprogram, then stream.
    // Idling: sender light and receiver heavy, then swapped, then none.
    for (p = 0; p < NumPhases; p++) begin
      drain_results();
      case (p / 2)
        0: begin tx_idle_pct = 33; rx_idle_pct = 63; end
        1: begin tx_idle_pct = 63; rx_idle_pct = 33; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case (p)
        0: begin
          // top extremes; bit 15 on a link length must be dropped
          write_reg(RegLink1Len, 16'hFFFF);
          write_reg(RegLink2Len, 16'hFFFF);
          write_reg(RegBaseX, 16'h7FFF);
          write_reg(RegBaseY, 16'h7FFF);
          write_reg(RegBaseZ, 16'h7FFF);
        end
        1: begin
          write_reg(RegLink1Len, 16'h0000);
          write_reg(RegLink2Len, 16'h0000);
          write_reg(RegBaseX, 16'h8000);
          write_reg(RegBaseY, 16'h8000);
          write_reg(RegBaseZ, 16'h8000);
        end
        2, 4: begin
          // modest settings keep most results clear of the clip
          write_reg(RegLink1Len, 16'($urandom_range(2047)));
          write_reg(RegLink2Len, 16'($urandom_range(2047)));
          write_reg(RegBaseX, 16'($urandom_range(4095)) - 16'd2048);
          write_reg(RegBaseY, 16'($urandom_range(4095)) - 16'd2048);
          write_reg(RegBaseZ, 16'($urandom_range(4095)) - 16'd2048);
        end
        default: begin
          write_reg(RegLink1Len, 16'($urandom));
          write_reg(RegLink2Len, 16'($urandom));
          write_reg(RegBaseX, 16'($urandom));
          write_reg(RegBaseY, 16'($urandom));
          write_reg(RegBaseZ, 16'($urandom));
        end
      endcase
      // a write to an unused index must leave every register alone
      write_reg(3'($urandom_range(AddrSpareHi, AddrSpareLo)), 16'($urandom));
      cfg_we_i <= 1'b0;
      @(negedge clk_i);

      for (k = 0; k < ItemsPerPhase; k++) begin
        w.ang1 = pick_angle();
        w.ang2 = pick_angle();
        w.px   = pick_coord();
        w.py   = pick_coord();
        w.pz   = pick_coord();
        send_word(w, predict_world(w));
      end
    end

    // Wait for the tail, then a little past the pipeline depth for strays.
    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("two_link_forward_kinematics_top test passed");
    end else begin
      $display("two_link_forward_kinematics_top test failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off twice during the random
  // part so the pipeline fills and the input side stalls behind it.
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    int next_hold_at;
    hold_left     = 0;
    next_hold_at  = 150;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (results_seen >= next_hold_at) begin
        hold_left    = RxHoldCycles;
        next_hold_at = next_hold_at + 450;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each accepted result word with the oldest expectation
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    results_seen = 0;
    mismatches   = 0;
  end

  always @(posedge clk_i) begin
    world_word_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_world.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, got %h",
                 $time, got);
        mismatches++;
      end else begin
        want = pending_world.pop_front();
        check_field("world_x", want.wx, got.wx);
        check_field("world_y", want.wy, got.wy);
        check_field("world_z", want.wz, got.wz);
        check_field("saturated", want.sat, got.sat);
        check_field("zero fill", want.fill, got.fill);
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: fails the run if it outlasts the timeout below; a correct run ends well
  // inside it even with every stall at its longest.
  // --------------------------------------------------------------------------
  initial begin
    #4_000_000;
    $display("two_link_forward_kinematics_top test failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: two_link_forward_kinematics_top.f
+incdir+design
design/fk_pkg.sv
design/fk_cordic.sv
design/two_link_forward_kinematics_top.sv
dv/two_link_forward_kinematics_top_tb.sv
